// File: rtl/smbser_pkg.sv
// Shared types and constants for the SMBIOS serial-number extractor.
// Depends on nothing; every other file of the block refers to it by scoped names.

package smbser_pkg;

   localparam int BYTE_W       = 8;
   localparam int TABLE_LEN_W  = 13;
   localparam int CSR_DATA_W   = 32;
   localparam int CSR_ADDR_W   = 3;

   localparam logic [7:0] MAX_SERIAL_LENGTH_RESET = 8'd32;

   // Register index as selected by paddr[2] (registers lie at byte 0 and byte 4).
   localparam logic REG_TABLE_LENGTH      = 1'b0;
   localparam logic REG_MAX_SERIAL_LENGTH = 1'b1;

   // Structure type whose header carries the serial number field.
   localparam logic [7:0] KIND_SYSTEM_INFO   = 8'd1;
   // A type-1 header needs at least this many bytes to hold the serial slot.
   localparam logic [7:0] SYSTEM_INFO_MIN_LEN = 8'h08;
   localparam logic [7:0] HEADER_MIN_LEN     = 8'd2;
   localparam logic [7:0] SERIAL_SLOT_POS    = 8'd7;
   localparam logic [7:0] NO_SLOT            = 8'hFF;
   // A structure cannot start when this many bytes or fewer remain.
   localparam logic [TABLE_LEN_W-1:0] MIN_STRUCT_BYTES = 13'd4;

   typedef struct packed {
      logic [TABLE_LEN_W-1:0] table_length;
      logic [BYTE_W-1:0]      max_serial_length;
      logic                   start;
   } cfg_type;

   typedef struct packed {
      logic              char_valid;
      logic [BYTE_W-1:0] serial_char;
      logic              done_res;
      logic              found;
   } result_type;

endpackage

// File: rtl/smbser_if.sv
// Valid/ready channel interfaces for table bytes and extracted serial results.
// Depends on smbser_pkg for the field widths.

interface smbser_req_if;
   logic                             valid;
   logic                             ready;
   logic [smbser_pkg::BYTE_W-1:0]    table_byte;

   modport source (output valid, output table_byte, input ready);
   modport sink   (input valid, input table_byte, output ready);
endinterface

interface smbser_rsp_if;
   logic                             valid;
   logic                             ready;
   logic                             char_valid;
   logic [smbser_pkg::BYTE_W-1:0]    serial_char;
   logic                             done_res;
   logic                             found;

   modport source (output valid, output char_valid, output serial_char,
                   output done_res, output found, input ready);
   modport sink   (input valid, input char_valid, input serial_char,
                   input done_res, input found, output ready);
endinterface

// File: rtl/smbser_csr.sv
// APB-style register file holding the table length and the serial length limit.
// Depends on smbser_pkg for widths, register indexes and the configuration struct.

module smbser_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [smbser_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [smbser_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [smbser_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                                 csr_pready,
   output smbser_pkg::cfg_type                  cfg
);

   logic [smbser_pkg::TABLE_LEN_W-1:0] table_length_ff, table_length_in;
   logic [smbser_pkg::BYTE_W-1:0]      max_len_ff, max_len_in;
   logic                               start_ff, start_in;
   logic                               wr_en;
   logic                               reg_sel;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel & csr_penable & csr_pwrite;
   assign reg_sel    = csr_paddr[2];

   always_comb begin
      table_length_in = table_length_ff;
      max_len_in      = max_len_ff;
      start_in        = 1'b0;
      if (wr_en) begin
         unique case (reg_sel)
            smbser_pkg::REG_TABLE_LENGTH: begin
               table_length_in = csr_pwdata[smbser_pkg::TABLE_LEN_W-1:0];
               start_in        = 1'b1;
            end
            smbser_pkg::REG_MAX_SERIAL_LENGTH: begin
               max_len_in = csr_pwdata[smbser_pkg::BYTE_W-1:0];
            end
            default: begin
               start_in = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         table_length_ff <= '0;
         max_len_ff      <= smbser_pkg::MAX_SERIAL_LENGTH_RESET;
         start_ff        <= 1'b0;
      end else begin
         table_length_ff <= table_length_in;
         max_len_ff      <= max_len_in;
         start_ff        <= start_in;
      end
   end

   always_comb begin
      unique case (reg_sel)
         smbser_pkg::REG_TABLE_LENGTH:
            csr_prdata = smbser_pkg::CSR_DATA_W'(table_length_ff);
         smbser_pkg::REG_MAX_SERIAL_LENGTH:
            csr_prdata = smbser_pkg::CSR_DATA_W'(max_len_ff);
         default:
            csr_prdata = '0;
      endcase
   end

   // The start pulse is registered and comes in the cycle after the write, ahead of any new byte.
   assign cfg.table_length      = table_length_ff;
   assign cfg.max_serial_length = max_len_ff;
   assign cfg.start             = start_ff;

endmodule

// File: rtl/smbser_core.sv
// Scan state and per-byte update of the structure walker and serial emitter.
// Depends on smbser_pkg for widths, constants and the configuration/result structs.

module smbser_core #(
   parameter int MAX_STRING_SLOTS = 16,
   parameter int MAX_TABLE_BYTES  = 4096
) (
   input  logic                              clock,
   input  logic                              reset,
   input  smbser_pkg::cfg_type               cfg,
   input  logic                              step_valid,
   input  logic [smbser_pkg::BYTE_W-1:0]     step_byte,
   output smbser_pkg::result_type            result,
   output logic                              has_result
);

   localparam int SNUM_W = $clog2(MAX_STRING_SLOTS + 2);
   localparam int LEN_W  = smbser_pkg::TABLE_LEN_W;

   localparam logic [2:0] PH_HEADER       = 3'd0;
   localparam logic [2:0] PH_STR_FIRST    = 3'd1;
   localparam logic [2:0] PH_STR_BODY     = 3'd2;
   localparam logic [2:0] PH_EMPTY_SECOND = 3'd3;
   localparam logic [2:0] PH_DONE         = 3'd4;

   logic [2:0]        phase_ff, phase_in;
   logic [7:0]        pos_ff, pos_in;
   logic [7:0]        len_ff, len_in;
   logic [7:0]        kind_ff, kind_in;
   logic [7:0]        slot_ff, slot_in;
   logic [LEN_W-1:0]  remaining_ff, remaining_in;
   logic [SNUM_W-1:0] snum_ff, snum_in;
   logic              prev_null_ff, prev_null_in;
   logic [7:0]        emitted_ff, emitted_in;

   logic [LEN_W-1:0]  start_remaining;
   logic              cv, dn, fd, section_end;
   logic [7:0]        ch, lim, new_slot;

   function automatic logic in_serial(input logic [2:0] ph, input logic [7:0] kind,
                                      input logic prev, input logic [SNUM_W-1:0] num,
                                      input logic [7:0] slot);
      in_serial = (ph == PH_STR_BODY) && (kind == smbser_pkg::KIND_SYSTEM_INFO) && !prev
                  && (num != '0) && (int'(num) - 1 == int'(slot));
   endfunction

   assign start_remaining = (32'(cfg.table_length) > 32'(MAX_TABLE_BYTES))
                            ? LEN_W'(MAX_TABLE_BYTES) : cfg.table_length;
   assign lim      = (cfg.max_serial_length == '0) ? 8'd1 : cfg.max_serial_length;
   assign new_slot = step_byte - 8'd1;

   always_comb begin
      phase_in     = phase_ff;
      pos_in       = pos_ff;
      len_in       = len_ff;
      kind_in      = kind_ff;
      slot_in      = slot_ff;
      remaining_in = remaining_ff;
      snum_in      = snum_ff;
      prev_null_in = prev_null_ff;
      emitted_in   = emitted_ff;
      cv           = 1'b0;
      dn           = 1'b0;
      fd           = 1'b0;
      ch           = '0;
      section_end  = 1'b0;

      if (step_valid && phase_ff != PH_DONE) begin
         if (remaining_ff == '0) begin
            phase_in = PH_DONE;
            dn       = 1'b1;
         end else begin
            remaining_in = remaining_ff - 1'b1;
            unique case (phase_ff)
               PH_HEADER: begin
                  if (pos_ff == 8'd0) begin
                     kind_in = step_byte;
                     if (remaining_ff <= smbser_pkg::MIN_STRUCT_BYTES) begin
                        phase_in = PH_DONE;
                        dn       = 1'b1;
                     end
                  end else if (pos_ff == 8'd1) begin
                     len_in = step_byte;
                     if (step_byte < smbser_pkg::HEADER_MIN_LEN
                         || (14'(step_byte) > (14'(remaining_ff) + 14'd1))
                         || (kind_ff == smbser_pkg::KIND_SYSTEM_INFO
                             && step_byte < smbser_pkg::SYSTEM_INFO_MIN_LEN)) begin
                        phase_in = PH_DONE;
                        dn       = 1'b1;
                     end
                  end else if (pos_ff == smbser_pkg::SERIAL_SLOT_POS
                               && kind_ff == smbser_pkg::KIND_SYSTEM_INFO) begin
                     if (9'(new_slot) >= 9'(MAX_STRING_SLOTS)) begin
                        phase_in = PH_DONE;
                        dn       = 1'b1;
                     end else begin
                        slot_in = new_slot;
                     end
                  end
                  if (phase_in != PH_DONE) begin
                     if (pos_ff != 8'd0 && (9'(pos_ff) + 9'd1) == 9'(len_in)) begin
                        phase_in     = PH_STR_FIRST;
                        snum_in      = '0;
                        prev_null_in = 1'b1;
                     end else begin
                        pos_in = pos_ff + 8'd1;
                     end
                  end
               end
               PH_EMPTY_SECOND: begin
                  section_end = 1'b1;
               end
               default: begin
                  // First byte of a string section or any later one.
                  if (phase_ff == PH_STR_FIRST && step_byte == '0) begin
                     phase_in = PH_EMPTY_SECOND;
                  end else begin
                     phase_in = PH_STR_BODY;
                     if (step_byte == '0) begin
                        if (prev_null_ff) begin
                           section_end = 1'b1;
                        end else begin
                           if (in_serial(PH_STR_BODY, kind_ff, 1'b0, snum_ff, slot_ff)) begin
                              phase_in = PH_DONE;
                              dn       = 1'b1;
                              fd       = 1'b1;
                           end
                           prev_null_in = 1'b1;
                        end
                     end else begin
                        if (prev_null_ff) begin
                           if (int'(snum_ff) <= MAX_STRING_SLOTS) begin
                              snum_in = snum_ff + 1'b1;
                           end
                           prev_null_in = 1'b0;
                        end
                        if (in_serial(PH_STR_BODY, kind_ff, prev_null_in, snum_in, slot_ff)) begin
                           cv         = 1'b1;
                           ch         = step_byte;
                           emitted_in = emitted_ff + 8'd1;
                           if (emitted_in >= lim) begin
                              phase_in = PH_DONE;
                              dn       = 1'b1;
                              fd       = 1'b1;
                           end
                        end
                     end
                  end
               end
            endcase

            if (section_end) begin
               if (kind_ff == smbser_pkg::KIND_SYSTEM_INFO) begin
                  phase_in = PH_DONE;
                  dn       = 1'b1;
               end else begin
                  phase_in     = PH_HEADER;
                  pos_in       = '0;
                  prev_null_in = 1'b0;
               end
            end

            if (phase_in != PH_DONE && remaining_in == '0) begin
               fd       = in_serial(phase_in, kind_in, prev_null_in, snum_in, slot_in);
               phase_in = PH_DONE;
               dn       = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_HEADER;
         pos_ff       <= '0;
         len_ff       <= '0;
         kind_ff      <= '0;
         slot_ff      <= smbser_pkg::NO_SLOT;
         remaining_ff <= '0;
         snum_ff      <= '0;
         prev_null_ff <= 1'b0;
         emitted_ff   <= '0;
      end else if (cfg.start) begin
         phase_ff     <= PH_HEADER;
         pos_ff       <= '0;
         len_ff       <= '0;
         kind_ff      <= '0;
         slot_ff      <= smbser_pkg::NO_SLOT;
         remaining_ff <= start_remaining;
         snum_ff      <= '0;
         prev_null_ff <= 1'b0;
         emitted_ff   <= '0;
      end else begin
         phase_ff     <= phase_in;
         pos_ff       <= pos_in;
         len_ff       <= len_in;
         kind_ff      <= kind_in;
         slot_ff      <= slot_in;
         remaining_ff <= remaining_in;
         snum_ff      <= snum_in;
         prev_null_ff <= prev_null_in;
         emitted_ff   <= emitted_in;
      end
   end

   assign has_result         = cv | dn;
   assign result.char_valid  = cv;
   assign result.serial_char = ch;
   assign result.done_res    = dn;
   assign result.found       = dn & fd;

endmodule

// File: rtl/smbios_serial_extractor_top.sv
// Top level of the SMBIOS serial-number extractor: request and result registers
// around the scan core, plus the APB-style register file.
// Depends on smbser_pkg, smbser_if.sv, smbser_csr and smbser_core.

// The block walks an SMBIOS3 structure table that arrives one byte per request
// on the req channel, after software has written the table length to register 0
// (byte address 0); that write also restarts the scan. Register 1 (byte address 4)
// sets the most serial characters emitted, where 0 acts as 1. The block skips
// every structure that is not type 1, and at the first type-1 structure it
// streams the serial number string out on the rsp channel, one character per
// result, and ends with a result that has done_res set and found telling
// whether the string was located. Requests that cause no character and do not
// end the scan give no result, and after the end every request is taken and
// dropped until the table length is written again; after reset the length is
// 0, so the first request ends the scan not found. One table byte is taken in
// every cycle: each request is held in an input register, updates the scan
// counters in combinational logic as it moves on, and lands its result in the
// output register, from which rsp presents it; it moves on once that register
// is free or being emptied. The rate stays at one request per cycle as long as
// the rsp side takes results; a stalled result holds the input register and
// then the req side. Configuration must be written only while no request is
// in flight.

module smbios_serial_extractor_top #(
   parameter int MAX_STRING_SLOTS = 16,
   parameter int MAX_TABLE_BYTES  = 4096
) (
   input  logic                                 clock,
   input  logic                                 reset,
   smbser_req_if.sink                           req,
   smbser_rsp_if.source                         rsp,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [smbser_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [smbser_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [smbser_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                                 csr_pready
);

   smbser_pkg::cfg_type     cfg;
   smbser_pkg::result_type  core_result;
   smbser_pkg::result_type  out_ff, out_in;
   logic                    core_has_result;

   // Input register: one accepted request waiting to be applied to the scan.
   logic                           in_valid_ff, in_valid_in;
   logic [smbser_pkg::BYTE_W-1:0]  in_byte_ff, in_byte_in;
   // Output register: one result waiting for the rsp side.
   logic                           out_valid_ff, out_valid_in;
   logic                           advance;
   logic                           req_take;

   smbser_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // The held request moves on whenever the output register is free or is
   // being emptied in this cycle.
   assign advance   = in_valid_ff & (~out_valid_ff | rsp.ready);
   assign req.ready = ~in_valid_ff | advance;
   assign req_take  = req.valid & req.ready;

   smbser_core #(
      .MAX_STRING_SLOTS (MAX_STRING_SLOTS),
      .MAX_TABLE_BYTES  (MAX_TABLE_BYTES)
   ) u_core (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .step_valid (advance),
      .step_byte  (in_byte_ff),
      .result     (core_result),
      .has_result (core_has_result)
   );

   always_comb begin
      in_valid_in = in_valid_ff;
      in_byte_in  = in_byte_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
         in_byte_in  = req.table_byte;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      out_in       = out_ff;
      if (advance) begin
         out_valid_in = core_has_result;
         out_in       = core_result;
      end else if (rsp.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_byte_ff <= in_byte_in;
      out_ff     <= out_in;
   end

   assign rsp.valid       = out_valid_ff;
   assign rsp.char_valid  = out_ff.char_valid;
   assign rsp.serial_char = out_ff.serial_char;
   assign rsp.done_res    = out_ff.done_res;
   assign rsp.found       = out_ff.found;

`ifndef NO_ASSERTIONS
   // A result always carries a character, the end of the scan, or both.
   a_result_nonempty: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> (out_ff.char_valid || out_ff.done_res))
      else $error("result with neither a character nor the end of the scan");

   // found is only reported on the result that ends the scan.
   a_found_needs_done: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> (!out_ff.found || out_ff.done_res))
      else $error("found set on a result that does not end the scan");

   // A result without a character carries a zero character field.
   a_char_zero: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !out_ff.char_valid) |-> (out_ff.serial_char == '0))
      else $error("serial_char nonzero without char_valid");

   // An empty input register always takes the next request.
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !in_valid_ff |-> req.ready)
      else $error("request refused while the input register is empty");

   // A stalled result leaves the held request in place.
   a_hold_on_stall: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && out_valid_ff && !rsp.ready) |=> (in_valid_ff && $stable(in_byte_ff)))
      else $error("held request lost while the result register stalls");
`endif

endmodule
